@@ rtl/tile_map_world_coordinate_convert_macros.svh @@
// ----------------------------------------------------------------------------
// tile map coordinate converter assertion macros
// shared property shapes for the checks at the end of the top level
// ----------------------------------------------------------------------------
`ifndef TILE_MAP_WORLD_COORDINATE_CONVERT_MACROS_SVH
`define TILE_MAP_WORLD_COORDINATE_CONVERT_MACROS_SVH

// condition must never be true
`define TMWC_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

// consequent in the same cycle
`define TMWC_IMPLY(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent in the next cycle
`define TMWC_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/tmwc_pkg.sv @@
// ----------------------------------------------------------------------------
// tmwc_pkg
// types and fixed constants of the tile map coordinate converter
// ----------------------------------------------------------------------------
package tmwc_pkg;

   localparam int TILE_BITS      = 9;
   localparam int MUL_W          = TILE_BITS + 1;
   localparam int DEN_W          = 2 * TILE_BITS;
   localparam int OUT_W          = 24;
   localparam int OUT_MAX        = 8388607;
   localparam int OUT_MIN        = -8388608;
   localparam int KIND_BITS      = 2;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [KIND_BITS-1:0] KIND_ORTHO = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_ISO   = 2'd1;

   localparam logic [CSR_INDEX_BITS-1:0] REG_MAP_KIND    = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TILE_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TILE_HEIGHT = 2'd2;

   localparam logic ACT_TO_WORLD = 1'b0;
   localparam logic ACT_TO_GRID  = 1'b1;

   localparam logic [KIND_BITS-1:0] KIND_RESET = KIND_ORTHO;
   localparam logic [TILE_BITS-1:0] TILE_RESET = 9'd32;
   localparam logic [DEN_W-1:0]     DEN_RESET  = 18'd1024;

   localparam int Q_DEPTH    = 4;
   localparam int Q_PTR_BITS = 2;
   localparam int Q_CNT_BITS = 3;

   typedef enum logic [2:0] {
      OP_PASS,
      OP_ORTHO_TO_WORLD,
      OP_ORTHO_TO_GRID,
      OP_ISO_TO_WORLD,
      OP_ISO_TO_GRID
   } op_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

@@ rtl/tmwc_front.sv @@
// ----------------------------------------------------------------------------
// tmwc_front
// accepts request words, picks the conversion and forms the tile products
// ----------------------------------------------------------------------------
module tmwc_front #(
   parameter int COORD_BITS = 16
) (
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_action,
   input  logic signed [COORD_BITS-1:0]           req_coord_x,
   input  logic signed [COORD_BITS-1:0]           req_coord_y,
   input  logic [tmwc_pkg::KIND_BITS-1:0]         map_kind,
   input  logic [tmwc_pkg::TILE_BITS-1:0]         tile_w,
   input  logic [tmwc_pkg::TILE_BITS-1:0]         tile_h,
   input  tmwc_pkg::q_status_type                 q_stat,
   output logic                                   push,
   output tmwc_pkg::op_type                       op,
   output logic signed [COORD_BITS+9:0]           prod_x,
   output logic signed [COORD_BITS+9:0]           prod_y
);

   localparam int OPND_W = COORD_BITS + 1;
   localparam int LANE_W = COORD_BITS + 10;

   logic signed [OPND_W-1:0]        x_ext;
   logic signed [OPND_W-1:0]        y_ext;
   logic signed [OPND_W-1:0]        opnd_x;
   logic signed [OPND_W-1:0]        opnd_y;
   logic [tmwc_pkg::MUL_W-1:0]      mul_x;
   logic [tmwc_pkg::MUL_W-1:0]      mul_y;

   assign x_ext = OPND_W'(req_coord_x);
   assign y_ext = OPND_W'(req_coord_y);

   always_comb begin
      case (map_kind)
         tmwc_pkg::KIND_ORTHO: begin
            if (req_action == tmwc_pkg::ACT_TO_GRID) begin
               op = tmwc_pkg::OP_ORTHO_TO_GRID;
            end else begin
               op = tmwc_pkg::OP_ORTHO_TO_WORLD;
            end
         end
         tmwc_pkg::KIND_ISO: begin
            if (req_action == tmwc_pkg::ACT_TO_GRID) begin
               op = tmwc_pkg::OP_ISO_TO_GRID;
            end else begin
               op = tmwc_pkg::OP_ISO_TO_WORLD;
            end
         end
         default: begin
            op = tmwc_pkg::OP_PASS;
         end
      endcase
   end

   always_comb begin
      opnd_x = x_ext;
      opnd_y = y_ext;
      mul_x  = tmwc_pkg::MUL_W'(1);
      mul_y  = tmwc_pkg::MUL_W'(1);
      case (op)
         tmwc_pkg::OP_ORTHO_TO_WORLD: begin
            mul_x = {1'b0, tile_w};
            mul_y = {1'b0, tile_h};
         end
         tmwc_pkg::OP_ISO_TO_WORLD: begin
            opnd_x = x_ext - y_ext;
            opnd_y = x_ext + y_ext;
            mul_x  = {1'b0, tile_w};
            mul_y  = {1'b0, tile_h};
         end
         // x*h and y*w, summed and differenced in the back end
         tmwc_pkg::OP_ISO_TO_GRID: begin
            mul_x = {1'b0, tile_h};
            mul_y = {1'b0, tile_w};
         end
         default: begin
         end
      endcase
   end

   assign prod_x = LANE_W'(opnd_x) * LANE_W'($signed(mul_x));
   assign prod_y = LANE_W'(opnd_y) * LANE_W'($signed(mul_y));

   assign push      = req_valid & ~q_stat.full;
   assign req_stall = q_stat.full;

endmodule

@@ rtl/tmwc_queue.sv @@
// ----------------------------------------------------------------------------
// tmwc_queue
// short word queue between the front end and the divider pipeline
// ----------------------------------------------------------------------------
module tmwc_queue #(
   parameter int COORD_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  tmwc_pkg::op_type               push_op,
   input  logic signed [COORD_BITS+9:0]   push_x,
   input  logic signed [COORD_BITS+9:0]   push_y,
   input  logic                           pop,
   output tmwc_pkg::q_status_type         q_stat,
   output tmwc_pkg::op_type               head_op,
   output logic signed [COORD_BITS+9:0]   head_x,
   output logic signed [COORD_BITS+9:0]   head_y
);

   localparam int LANE_W = COORD_BITS + 10;

   tmwc_pkg::op_type                 entry_op_ff [tmwc_pkg::Q_DEPTH];
   logic signed [LANE_W-1:0]         entry_x_ff  [tmwc_pkg::Q_DEPTH];
   logic signed [LANE_W-1:0]         entry_y_ff  [tmwc_pkg::Q_DEPTH];
   logic [tmwc_pkg::Q_PTR_BITS-1:0]  wr_ptr_ff;
   logic [tmwc_pkg::Q_PTR_BITS-1:0]  rd_ptr_ff;
   logic [tmwc_pkg::Q_CNT_BITS-1:0]  count_ff;
   logic [tmwc_pkg::Q_CNT_BITS-1:0]  count_in;
   logic                             do_pop;

   assign q_stat.full  = (count_ff == tmwc_pkg::Q_CNT_BITS'(tmwc_pkg::Q_DEPTH));
   assign q_stat.empty = (count_ff == '0);
   assign do_pop       = pop & ~q_stat.empty;

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + tmwc_pkg::Q_CNT_BITS'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - tmwc_pkg::Q_CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + tmwc_pkg::Q_PTR_BITS'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + tmwc_pkg::Q_PTR_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_op_ff[wr_ptr_ff] <= push_op;
         entry_x_ff[wr_ptr_ff]  <= push_x;
         entry_y_ff[wr_ptr_ff]  <= push_y;
      end
   end

   assign head_op = entry_op_ff[rd_ptr_ff];
   assign head_x  = entry_x_ff[rd_ptr_ff];
   assign head_y  = entry_y_ff[rd_ptr_ff];

endmodule

@@ rtl/tmwc_back.sv @@
// ----------------------------------------------------------------------------
// tmwc_back
// sums and halves, pipelined restoring divider, saturation and response reg
// ----------------------------------------------------------------------------
module tmwc_back #(
   parameter int COORD_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  tmwc_pkg::q_status_type               q_stat,
   input  tmwc_pkg::op_type                     head_op,
   input  logic signed [COORD_BITS+9:0]         head_x,
   input  logic signed [COORD_BITS+9:0]         head_y,
   input  logic [tmwc_pkg::DEN_W-1:0]           div_x,
   input  logic [tmwc_pkg::DEN_W-1:0]           div_y,
   output logic                                 pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [tmwc_pkg::OUT_W-1:0]    rsp_result_x,
   output logic signed [tmwc_pkg::OUT_W-1:0]    rsp_result_y
);

   localparam int LANE_W = COORD_BITS + 10;
   localparam int NSTEP  = LANE_W;
   localparam int REM_W  = tmwc_pkg::DEN_W + 1;
   localparam int FIN_W  = LANE_W + 1;
   localparam int SAT_W  = (FIN_W > tmwc_pkg::OUT_W) ? FIN_W : tmwc_pkg::OUT_W + 1;
   localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'(tmwc_pkg::OUT_MAX);
   localparam logic signed [SAT_W-1:0] SAT_LO = SAT_W'(tmwc_pkg::OUT_MIN);

   logic                          adv;
   logic [tmwc_pkg::DEN_W-1:0]    lane_div [2];

   // prep stage inputs
   logic signed [LANE_W-1:0]      head_p   [2];
   logic signed [LANE_W-1:0]      adj_p    [2];
   logic signed [LANE_W-1:0]      half_p   [2];
   logic signed [LANE_W-1:0]      prep_val [2];
   logic                          prep_div;

   // pipeline stages, index 0 is the prep stage
   logic                          stg_valid_ff [NSTEP+1];
   tmwc_pkg::op_type              stg_op_ff    [NSTEP+1];
   logic                          stg_div_ff   [NSTEP+1];
   logic                          stg_neg_ff   [NSTEP+1][2];
   logic [LANE_W-1:0]             stg_quo_ff   [NSTEP+1][2];
   logic [tmwc_pkg::DEN_W-1:0]    stg_rem_ff   [NSTEP+1][2];
   logic                          stg_neg_in   [NSTEP+1][2];
   logic [LANE_W-1:0]             stg_quo_in   [NSTEP+1][2];
   logic [tmwc_pkg::DEN_W-1:0]    stg_rem_in   [NSTEP+1][2];

   logic signed [tmwc_pkg::OUT_W-1:0] fin_res   [2];
   logic                              rsp_valid_ff;
   logic signed [tmwc_pkg::OUT_W-1:0] rsp_res_ff [2];

   assign adv         = ~rsp_valid_ff | ~rsp_stall;
   assign pop         = adv & ~q_stat.empty;
   assign lane_div[0] = div_x;
   assign lane_div[1] = div_y;
   assign head_p[0]   = head_x;
   assign head_p[1]   = head_y;

   always_comb begin
      prep_div = head_op inside {tmwc_pkg::OP_ORTHO_TO_GRID, tmwc_pkg::OP_ISO_TO_GRID};
   end

   for (genvar j = 0; j < 2; j++) begin : g_prep
      // halving truncates toward zero: add one to negative values first
      assign adj_p[j]  = head_p[j] + {{(LANE_W-1){1'b0}}, head_p[j][LANE_W-1]};
      assign half_p[j] = adj_p[j] >>> 1;

      always_comb begin
         case (head_op)
            tmwc_pkg::OP_ISO_TO_GRID: begin
               if (j == 0) begin
                  prep_val[j] = head_p[0] + head_p[1];
               end else begin
                  prep_val[j] = head_p[1] - head_p[0];
               end
            end
            tmwc_pkg::OP_ISO_TO_WORLD: begin
               prep_val[j] = half_p[j];
            end
            default: begin
               prep_val[j] = head_p[j];
            end
         endcase
         stg_neg_in[0][j] = prep_div & prep_val[j][LANE_W-1];
         if (stg_neg_in[0][j]) begin
            stg_quo_in[0][j] = LANE_W'(-prep_val[j]);
         end else begin
            stg_quo_in[0][j] = prep_val[j];
         end
         stg_rem_in[0][j] = '0;
      end
   end

   // one quotient bit per stage
   for (genvar s = 1; s <= NSTEP; s++) begin : g_step
      for (genvar j = 0; j < 2; j++) begin : g_lane
         logic [REM_W-1:0] trial;
         logic             fits;

         assign trial = {stg_rem_ff[s-1][j], stg_quo_ff[s-1][j][LANE_W-1]};
         assign fits  = (trial >= {1'b0, lane_div[j]});

         always_comb begin
            stg_neg_in[s][j] = stg_neg_ff[s-1][j];
            stg_quo_in[s][j] = stg_quo_ff[s-1][j];
            stg_rem_in[s][j] = stg_rem_ff[s-1][j];
            if (stg_div_ff[s-1]) begin
               stg_quo_in[s][j] = {stg_quo_ff[s-1][j][LANE_W-2:0], fits};
               if (fits) begin
                  stg_rem_in[s][j] = tmwc_pkg::DEN_W'(trial - {1'b0, lane_div[j]});
               end else begin
                  stg_rem_in[s][j] = trial[tmwc_pkg::DEN_W-1:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= NSTEP; s++) begin
            stg_valid_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         stg_valid_ff[0] <= pop;
         for (int s = 1; s <= NSTEP; s++) begin
            stg_valid_ff[s] <= stg_valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         stg_op_ff[0]  <= head_op;
         stg_div_ff[0] <= prep_div;
         for (int s = 1; s <= NSTEP; s++) begin
            stg_op_ff[s]  <= stg_op_ff[s-1];
            stg_div_ff[s] <= stg_div_ff[s-1];
         end
         for (int s = 0; s <= NSTEP; s++) begin
            for (int j = 0; j < 2; j++) begin
               stg_neg_ff[s][j] <= stg_neg_in[s][j];
               stg_quo_ff[s][j] <= stg_quo_in[s][j];
               stg_rem_ff[s][j] <= stg_rem_in[s][j];
            end
         end
      end
   end

   // sign, the isometric x offset and saturation
   for (genvar j = 0; j < 2; j++) begin : g_fin
      logic signed [FIN_W-1:0] qmag;
      logic signed [FIN_W-1:0] fin;
      logic signed [SAT_W-1:0] wide;

      assign qmag = {1'b0, stg_quo_ff[NSTEP][j]};

      always_comb begin
         if (stg_div_ff[NSTEP]) begin
            if (stg_neg_ff[NSTEP][j]) begin
               fin = -qmag;
            end else begin
               fin = qmag;
            end
            if (j == 0 && stg_op_ff[NSTEP] == tmwc_pkg::OP_ISO_TO_GRID) begin
               fin = fin - FIN_W'(1);
            end
         end else begin
            fin = FIN_W'($signed(stg_quo_ff[NSTEP][j]));
         end
         wide = SAT_W'(fin);
         if (wide > SAT_HI) begin
            fin_res[j] = tmwc_pkg::OUT_W'(tmwc_pkg::OUT_MAX);
         end else if (wide < SAT_LO) begin
            fin_res[j] = tmwc_pkg::OUT_W'(tmwc_pkg::OUT_MIN);
         end else begin
            fin_res[j] = wide[tmwc_pkg::OUT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= stg_valid_ff[NSTEP];
      end
   end

   always_ff @(posedge clock) begin
      if (adv && stg_valid_ff[NSTEP]) begin
         rsp_res_ff[0] <= fin_res[0];
         rsp_res_ff[1] <= fin_res[1];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_result_x = rsp_res_ff[0];
   assign rsp_result_y = rsp_res_ff[1];

endmodule

@@ rtl/tile_map_world_coordinate_convert.sv @@
// ----------------------------------------------------------------------------
// tile_map_world_coordinate_convert
// tile grid <-> world pixel converter for orthogonal and isometric maps
// ----------------------------------------------------------------------------
// usage:
//  - csr port: write map_kind, tile_pixel_width, tile_pixel_height by index
//    while no word is in flight; a tile size of zero is used as one
//  - req channel: one word per conversion (action, coord_x, coord_y),
//    taken at an edge with req_valid high and req_stall low
//  - rsp channel: one word per request, in order, result_x/result_y
//    saturated to 24 bits, taken when rsp_valid is high and rsp_stall low
//  - throughput: one word per cycle, sustained while rsp_stall stays low
//  - path: queue, prep stage, then the COORD_BITS + 10 step restoring
//    divider and the response register, which every word passes through
//  - a stalled rsp freezes the divider pipeline; the four-word queue in
//    front of it keeps taking words until it fills, then req_stall rises
//  - reset: queue and pipeline empty, map_kind orthogonal, 32x32 tiles
// ----------------------------------------------------------------------------
`include "tile_map_world_coordinate_convert_macros.svh"

module tile_map_world_coordinate_convert #(
   parameter int COORD_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write_enable,
   input  logic [tmwc_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [tmwc_pkg::TILE_BITS-1:0]          csr_write_data,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic                                    req_action,
   input  logic signed [COORD_BITS-1:0]            req_coord_x,
   input  logic signed [COORD_BITS-1:0]            req_coord_y,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [tmwc_pkg::OUT_W-1:0]       rsp_result_x,
   output logic signed [tmwc_pkg::OUT_W-1:0]       rsp_result_y
);

   localparam int LANE_W = COORD_BITS + 10;

   logic [tmwc_pkg::KIND_BITS-1:0]  map_kind_ff;
   logic [tmwc_pkg::TILE_BITS-1:0]  tile_w_ff;
   logic [tmwc_pkg::TILE_BITS-1:0]  tile_h_ff;
   logic [tmwc_pkg::DEN_W-1:0]      den_ff;
   logic [tmwc_pkg::TILE_BITS-1:0]  tile_w_eff;
   logic [tmwc_pkg::TILE_BITS-1:0]  tile_h_eff;
   logic [tmwc_pkg::DEN_W-1:0]      div_x;
   logic [tmwc_pkg::DEN_W-1:0]      div_y;

   tmwc_pkg::q_status_type          q_stat;
   logic                            q_push;
   logic                            q_pop;
   tmwc_pkg::op_type                push_op;
   tmwc_pkg::op_type                head_op;
   logic signed [LANE_W-1:0]        push_x;
   logic signed [LANE_W-1:0]        push_y;
   logic signed [LANE_W-1:0]        head_x;
   logic signed [LANE_W-1:0]        head_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_kind_ff <= tmwc_pkg::KIND_RESET;
         tile_w_ff   <= tmwc_pkg::TILE_RESET;
         tile_h_ff   <= tmwc_pkg::TILE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            tmwc_pkg::REG_MAP_KIND: begin
               map_kind_ff <= csr_write_data[tmwc_pkg::KIND_BITS-1:0];
            end
            tmwc_pkg::REG_TILE_WIDTH: begin
               tile_w_ff <= csr_write_data;
            end
            tmwc_pkg::REG_TILE_HEIGHT: begin
               tile_h_ff <= csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   assign tile_w_eff = (tile_w_ff == '0) ? tmwc_pkg::TILE_BITS'(1) : tile_w_ff;
   assign tile_h_eff = (tile_h_ff == '0) ? tmwc_pkg::TILE_BITS'(1) : tile_h_ff;

   // tile area for the isometric inverse, settles long before any division
   always_ff @(posedge clock) begin
      if (reset) begin
         den_ff <= tmwc_pkg::DEN_RESET;
      end else begin
         den_ff <= tmwc_pkg::DEN_W'(tile_w_eff) * tmwc_pkg::DEN_W'(tile_h_eff);
      end
   end

   assign div_x = (map_kind_ff == tmwc_pkg::KIND_ISO) ? den_ff : tmwc_pkg::DEN_W'(tile_w_eff);
   assign div_y = (map_kind_ff == tmwc_pkg::KIND_ISO) ? den_ff : tmwc_pkg::DEN_W'(tile_h_eff);

   tmwc_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_action  (req_action),
      .req_coord_x (req_coord_x),
      .req_coord_y (req_coord_y),
      .map_kind    (map_kind_ff),
      .tile_w      (tile_w_eff),
      .tile_h      (tile_h_eff),
      .q_stat      (q_stat),
      .push        (q_push),
      .op          (push_op),
      .prod_x      (push_x),
      .prod_y      (push_y)
   );

   tmwc_queue #(
      .COORD_BITS (COORD_BITS)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (push_op),
      .push_x  (push_x),
      .push_y  (push_y),
      .pop     (q_pop),
      .q_stat  (q_stat),
      .head_op (head_op),
      .head_x  (head_x),
      .head_y  (head_y)
   );

   tmwc_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_stat       (q_stat),
      .head_op      (head_op),
      .head_x       (head_x),
      .head_y       (head_y),
      .div_x        (div_x),
      .div_y        (div_y),
      .pop          (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_result_x (rsp_result_x),
      .rsp_result_y (rsp_result_y)
   );

   `TMWC_NEVER(a_push_when_full, clock, reset, q_push && q_stat.full, "word pushed into full queue")
   `TMWC_NEVER(a_pop_when_empty, clock, reset, q_pop && q_stat.empty, "word popped from empty queue")
   `TMWC_IMPLY(a_hold_on_stall, clock, reset, rsp_valid && rsp_stall, !q_pop, "back end moved under stall")
   `TMWC_NEXT(a_empty_stays, clock, reset, q_stat.empty && !q_push, q_stat.empty, "queue filled without push")

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tile map coordinate converter testbench
// drives conversion words through the req channel under several map kinds
// and tile sizes, predicts each converted point and checks every rsp word in
// order; both channels idle at random, and once the rsp side holds off long
// enough for the input queue to fill
// ----------------------------------------------------------------------------
module tb;

   localparam int COORD_BITS = 16;
   localparam logic [tmwc_pkg::KIND_BITS-1:0] KIND_PASS  = 2'd2;
   localparam logic [tmwc_pkg::KIND_BITS-1:0] KIND_SPARE = 2'd3;
   localparam int RANDOM_PHASES = 12;
   localparam int HOLD_PHASE    = 2;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_CYCLES  = 40;

   // expected converted points, oldest first
   class coord_scoreboard_type;
      typedef struct {
         logic signed [tmwc_pkg::OUT_W-1:0] x;
         logic signed [tmwc_pkg::OUT_W-1:0] y;
      } coord_pair_type;

      coord_pair_type expected_points[$];
      logic [tmwc_pkg::KIND_BITS-1:0] kind;
      logic [tmwc_pkg::TILE_BITS-1:0] width;
      logic [tmwc_pkg::TILE_BITS-1:0] height;
      int errors;

      function new();
         kind   = tmwc_pkg::KIND_RESET;
         width  = tmwc_pkg::TILE_RESET;
         height = tmwc_pkg::TILE_RESET;
         errors = 0;
      endfunction

      function void set_register(logic [tmwc_pkg::CSR_INDEX_BITS-1:0] idx,
                                 logic [tmwc_pkg::TILE_BITS-1:0] val);
         case (idx)
            tmwc_pkg::REG_MAP_KIND:    kind   = val[tmwc_pkg::KIND_BITS-1:0];
            tmwc_pkg::REG_TILE_WIDTH:  width  = val;
            tmwc_pkg::REG_TILE_HEIGHT: height = val;
            default: ;
         endcase
      endfunction

      function logic signed [tmwc_pkg::OUT_W-1:0] saturate_out(longint v);
         if (v > tmwc_pkg::OUT_MAX) return tmwc_pkg::OUT_W'(tmwc_pkg::OUT_MAX);
         if (v < tmwc_pkg::OUT_MIN) return tmwc_pkg::OUT_W'(tmwc_pkg::OUT_MIN);
         return v[tmwc_pkg::OUT_W-1:0];
      endfunction

      function coord_pair_type convert_point(logic act, logic signed [COORD_BITS-1:0] cx,
                                             logic signed [COORD_BITS-1:0] cy);
         longint x, y, w, h, rx, ry;
         coord_pair_type p;
         x = cx;
         y = cy;
         // a zero tile size counts as one
         w = (width == 0) ? 64'sd1 : longint'(width);
         h = (height == 0) ? 64'sd1 : longint'(height);
         if (kind == tmwc_pkg::KIND_ORTHO) begin
            if (act == tmwc_pkg::ACT_TO_GRID) begin
               rx = x / w;
               ry = y / h;
            end else begin
               rx = x * w;
               ry = y * h;
            end
         end else if (kind == tmwc_pkg::KIND_ISO) begin
            if (act == tmwc_pkg::ACT_TO_GRID) begin
               rx = (x * h + y * w) / (w * h) - 1;
               ry = (y * w - x * h) / (w * h);
            end else begin
               rx = ((x - y) * w) / 2;
               ry = ((x + y) * h) / 2;
            end
         end else begin
            rx = x;
            ry = y;
         end
         p.x = saturate_out(rx);
         p.y = saturate_out(ry);
         return p;
      endfunction

      function void note_request(logic act, logic signed [COORD_BITS-1:0] cx,
                                 logic signed [COORD_BITS-1:0] cy);
         expected_points.insert(expected_points.size(), convert_point(act, cx, cy));
      endfunction

      function void check_result(logic signed [tmwc_pkg::OUT_W-1:0] rx,
                                 logic signed [tmwc_pkg::OUT_W-1:0] ry);
         coord_pair_type p;
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected rsp word x=%0d y=%0d", $time, rx, ry);
            errors++;
            return;
         end
         p = expected_points.pop_front();
         if (rx !== p.x) begin
            $display("%0t: result_x expected %0d got %0d", $time, p.x, rx);
            errors++;
         end
         if (ry !== p.y) begin
            $display("%0t: result_y expected %0d got %0d", $time, p.y, ry);
            errors++;
         end
      endfunction

      function int pending();
         return expected_points.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [tmwc_pkg::CSR_INDEX_BITS-1:0] csr_index = tmwc_pkg::REG_MAP_KIND;
   logic [tmwc_pkg::TILE_BITS-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_action = tmwc_pkg::ACT_TO_WORLD;
   logic signed [COORD_BITS-1:0] req_coord_x = '0;
   logic signed [COORD_BITS-1:0] req_coord_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [tmwc_pkg::OUT_W-1:0] rsp_result_x;
   logic signed [tmwc_pkg::OUT_W-1:0] rsp_result_y;

   bit send_idling = 1'b1;
   bit take_idling = 1'b1;
   bit hold_request = 1'b0;

   coord_scoreboard_type board = new();

   tile_map_world_coordinate_convert #(
      .COORD_BITS(COORD_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_action(req_action),
      .req_coord_x(req_coord_x),
      .req_coord_y(req_coord_y),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_x(rsp_result_x),
      .rsp_result_y(rsp_result_y)
   );

   always #5 clock = ~clock;

   // mostly none, often short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic signed [COORD_BITS-1:0] pick_coord();
      int r;
      int v;
      r = $urandom_range(0, 9);
      if (r < 4) return COORD_BITS'($urandom);
      if (r < 8) begin
         v = int'($urandom_range(0, 600)) - 300;
         return v[COORD_BITS-1:0];
      end
      if (r == 8) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      v = int'($urandom_range(0, 64)) - 32;
      return v[COORD_BITS-1:0];
   endfunction

   function automatic logic [tmwc_pkg::TILE_BITS-1:0] pick_tile();
      case ($urandom_range(0, 9))
         0: return 9'd0;
         1: return 9'd1;
         2: return 9'd256;
         3: return 9'd511;
         4: return tmwc_pkg::TILE_BITS'($urandom_range(257, 511));
         default: return tmwc_pkg::TILE_BITS'($urandom_range(1, 256));
      endcase
   endfunction

   function automatic logic [tmwc_pkg::KIND_BITS-1:0] pick_kind();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4) return tmwc_pkg::KIND_ORTHO;
      if (r < 8) return tmwc_pkg::KIND_ISO;
      if (r == 8) return KIND_PASS;
      return KIND_SPARE;
   endfunction

   // only called with nothing in flight
   task automatic write_settings(input logic [tmwc_pkg::KIND_BITS-1:0] kind,
                                 input logic [tmwc_pkg::TILE_BITS-1:0] w,
                                 input logic [tmwc_pkg::TILE_BITS-1:0] h);
      csr_write_enable <= 1'b1;
      csr_index <= tmwc_pkg::REG_MAP_KIND;
      csr_write_data <= {{(tmwc_pkg::TILE_BITS-tmwc_pkg::KIND_BITS){1'b0}}, kind};
      @(posedge clock);
      csr_index <= tmwc_pkg::REG_TILE_WIDTH;
      csr_write_data <= w;
      @(posedge clock);
      csr_index <= tmwc_pkg::REG_TILE_HEIGHT;
      csr_write_data <= h;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      board.set_register(tmwc_pkg::REG_MAP_KIND,
                         {{(tmwc_pkg::TILE_BITS-tmwc_pkg::KIND_BITS){1'b0}}, kind});
      board.set_register(tmwc_pkg::REG_TILE_WIDTH, w);
      board.set_register(tmwc_pkg::REG_TILE_HEIGHT, h);
   endtask

   task automatic send_word(input logic act, input logic signed [COORD_BITS-1:0] cx,
                            input logic signed [COORD_BITS-1:0] cy);
      int gap;
      gap = send_idling ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_coord_x <= cx;
      req_coord_y <= cy;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(act, cx, cy);
   endtask

   task automatic finish_phase();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
   endtask

   // rsp side: checks each word taken and drives its own stall pattern
   initial begin : receiver
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall)
            board.check_result(rsp_result_x, rsp_result_y);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && take_idling) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : stimulus
      int count;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // reset settings: orthogonal 32x32
      send_word(tmwc_pkg::ACT_TO_WORLD, 16'sh7fff, 16'sh8000);
      send_word(tmwc_pkg::ACT_TO_GRID, 16'sh8000, 16'sh7fff);
      send_word(tmwc_pkg::ACT_TO_GRID, COORD_BITS'(-33), COORD_BITS'(31));
      finish_phase();
      // a tile size of 256 scales the extremes to the edge of the 24-bit range
      write_settings(tmwc_pkg::KIND_ORTHO, 9'd256, 9'd256);
      send_word(tmwc_pkg::ACT_TO_WORLD, 16'sh7fff, 16'sh7fff);
      send_word(tmwc_pkg::ACT_TO_WORLD, 16'sh8000, 16'sh8000);
      send_word(tmwc_pkg::ACT_TO_GRID, COORD_BITS'(-255), COORD_BITS'(255));
      finish_phase();
      write_settings(tmwc_pkg::KIND_ISO, 9'd256, 9'd1);
      send_word(tmwc_pkg::ACT_TO_WORLD, 16'sh7fff, 16'sh8000);
      send_word(tmwc_pkg::ACT_TO_GRID, 16'sh8000, 16'sh8000);
      send_word(tmwc_pkg::ACT_TO_GRID, COORD_BITS'(100), COORD_BITS'(-7));
      send_word(tmwc_pkg::ACT_TO_WORLD, COORD_BITS'(-3), COORD_BITS'(4));
      finish_phase();
      write_settings(KIND_PASS, 9'd32, 9'd32);
      send_word(tmwc_pkg::ACT_TO_WORLD, 16'sh8000, 16'sh7fff);
      send_word(tmwc_pkg::ACT_TO_GRID, 16'sh7fff, COORD_BITS'(0));
      finish_phase();
      // kind three passes through like kind two
      write_settings(KIND_SPARE, 9'd1, 9'd1);
      send_word(tmwc_pkg::ACT_TO_GRID, COORD_BITS'(12345), COORD_BITS'(-1));
      finish_phase();
      // zero tile size used as one, oversize used as written
      write_settings(tmwc_pkg::KIND_ORTHO, 9'd0, 9'd511);
      send_word(tmwc_pkg::ACT_TO_WORLD, 16'sh8000, 16'sh7fff);
      send_word(tmwc_pkg::ACT_TO_GRID, 16'sh7fff, 16'sh8000);
      finish_phase();
      write_settings(tmwc_pkg::KIND_ISO, 9'd511, 9'd0);
      send_word(tmwc_pkg::ACT_TO_GRID, 16'sh7fff, 16'sh7fff);
      send_word(tmwc_pkg::ACT_TO_WORLD, 16'sh8000, 16'sh7fff);
      finish_phase();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         send_idling = (ph % 4) != 3 && ph != HOLD_PHASE;
         take_idling = (ph % 4) != 3;
         write_settings(pick_kind(), pick_tile(), pick_tile());
         // long rsp hold-off with the sender pushing back to back
         if (ph == HOLD_PHASE) hold_request = 1'b1;
         count = (ph == HOLD_PHASE) ? 60 : 36;
         for (int i = 0; i < count; i++)
            send_word(logic'($urandom_range(0, 1)), pick_coord(), pick_coord());
         finish_phase();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
